>>> sv/tel_pkg.sv
// ----------------------------------------------------------------------------
// tel_pkg: shared types and constants for the timer expiry list
// Command codes, list entry layout and the control word of one list cell.
// ----------------------------------------------------------------------------
package tel_pkg;

    localparam int ID_W       = 4;
    localparam int TIME_W     = 64;
    localparam int INC_W      = 8;
    localparam int CMD_W      = 2;
    localparam logic [INC_W-1:0] TICK_RESET = 8'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARM    = 2'd0,
        CMD_DISARM = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_LOAD
    } cell_op_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins_data;
    } cell_ctl_t;

endpackage

>>> sv/tel_in_if.sv
// ----------------------------------------------------------------------------
// tel_in_if: command channel of the timer expiry list
// Valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface tel_in_if
    import tel_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] expiry_time;

    modport source (output valid, output cmd, output timer_id, output expiry_time,
                    input ready);
    modport sink   (input valid, input cmd, input timer_id, input expiry_time,
                    output ready);
endinterface

>>> sv/tel_out_if.sv
// ----------------------------------------------------------------------------
// tel_out_if: result channel of the timer expiry list
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface tel_out_if
    import tel_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   result_id;
    logic              hit;
    logic [TIME_W-1:0] current_time;
    logic              last_of_run;

    modport source (output valid, output result_id, output hit, output current_time,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_id, input hit, input current_time,
                    input last_of_run, output ready);
endinterface

>>> sv/tel_cell.sv
// ----------------------------------------------------------------------------
// tel_cell: one slot of the timer order list
// Holds a timer id and its expiry; shifts from its right neighbor or loads
// the insert bus when selected.
// ----------------------------------------------------------------------------
module tel_cell
    import tel_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      sel,
    input  entry_t    right,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // pick next slot content
    always_comb
    begin
        case (ctl.op)
            OP_SHIFT: entry_next = sel ? ctl.ins_data : right;
            OP_LOAD:  entry_next = sel ? ctl.ins_data : entry_reg;
            default:  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> sv/timer_expiry_list.sv
// ----------------------------------------------------------------------------
// timer_expiry_list: one-shot timers kept in arming order
// A chain of list cells holds armed timers in order; a rotating scan walks
// the chain for ticks and for unlinking a timer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries commands (arm, disarm, query, tick); out_ch returns result
//   items, the last one of each command marked by last_of_run. cfg_we/cfg_wdata
//   set the tick increment; write it only while the block is idle.
//   Query, disarm of an unarmed timer, arm of an unarmed timer, an invalid id
//   and a tick on an empty list finish in the idle state: the result is
//   loaded into the output register as the command is taken.
//   Rearm, disarm of an armed timer and a tick with armed timers pass through
//   the scan state: the head cell is examined once per unstalled cycle while the
//   list rotates through the cell chain, then the finish state ends the command.
//   Fired timers of a tick leave one per scan cycle; a stalled receiver holds
//   the scan when a second fired id is waiting.
//   A new command is taken in the idle state when the output register is free
//   or being emptied.
//   Reset clears the time, the armed flags, the list length and sets the tick
//   increment to 8.
// ----------------------------------------------------------------------------
module timer_expiry_list
    import tel_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    tel_in_if.sink           in_ch,
    tel_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [INC_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                  state_reg,     state_next;
    logic [TIME_W-1:0]       now_reg,       now_next;
    logic [INC_W-1:0]        inc_reg;
    logic [CNT_W-1:0]        len_reg,       len_next;
    logic [CNT_W-1:0]        remain_reg,    remain_next;
    logic [NUM_TIMERS-1:0]   flags_reg,     flags_next;
    cmd_t                    cmd_reg,       cmd_next;
    logic [ID_W-1:0]         target_reg,    target_next;
    logic [TIME_W-1:0]       exp_reg,       exp_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]         pend_id_reg,   pend_id_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ID_W-1:0]         out_id_reg,    out_id_next;
    logic                    out_hit_reg,   out_hit_next;
    logic [TIME_W-1:0]       out_time_reg,  out_time_next;
    logic                    out_last_reg,  out_last_next;

    cell_ctl_t               ctl;
    logic [CNT_W-1:0]        ins_pos;
    logic [NUM_TIMERS-1:0]   sel;
    entry_t                  cells [NUM_TIMERS];
    entry_t                  head;
    logic [TIME_W-1:0]       diff;
    logic                    expired;
    logic                    drop;
    logic                    out_free;
    logic                    in_fire;
    cmd_t                    in_cmd;
    logic                    id_valid;
    logic [IDX_W-1:0]        in_idx;
    logic [IDX_W-1:0]        head_idx;
    logic [IDX_W-1:0]        target_idx;
    logic                    load_out;
    logic [ID_W-1:0]         ld_id;
    logic                    ld_hit;
    logic                    ld_last;

    // row of list cells
    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            entry_t right;
            if (g == NUM_TIMERS - 1)
            begin : g_tail
                assign right = ctl.ins_data;
            end
            else
            begin : g_mid
                assign right = cells[g + 1];
            end
            assign sel[g] = (ins_pos == CNT_W'(g));
            tel_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .sel   (sel[g]),
                .right (right),
                .entry (cells[g])
            );
        end
    endgenerate

    // head compare against the current time or the target id
    assign head     = cells[0];
    assign diff     = head.expiry - now_reg;
    assign expired  = diff[TIME_W-1];
    assign drop     = (cmd_reg == CMD_TICK) ? expired : (head.id == target_reg);

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign in_cmd     = cmd_t'(in_ch.cmd);
    assign id_valid   = int'(in_ch.timer_id) < NUM_TIMERS;
    assign in_idx     = IDX_W'(in_ch.timer_id);
    assign head_idx   = IDX_W'(head.id);
    assign target_idx = IDX_W'(target_reg);

    // command sequencing
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        flags_next      = flags_reg;
        cmd_next        = cmd_reg;
        target_next     = target_reg;
        exp_next        = exp_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        ctl.op          = OP_HOLD;
        ctl.ins_data    = head;
        ins_pos         = len_reg;
        load_out        = 1'b0;
        ld_id           = in_ch.timer_id;
        ld_hit          = 1'b0;
        ld_last         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    target_next = in_ch.timer_id;
                    exp_next    = in_ch.expiry_time;
                    cmd_next    = in_cmd;
                    if (in_cmd == CMD_TICK)
                    begin
                        now_next = now_reg + TIME_W'(inc_reg);
                        if (len_reg == '0)
                        begin
                            load_out = 1'b1;
                            ld_id    = '0;
                        end
                        else
                        begin
                            remain_next     = len_reg;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    end
                    else if (!id_valid)
                    begin
                        load_out = 1'b1;
                    end
                    else
                    begin
                        case (in_cmd)
                            CMD_QUERY:
                            begin
                                load_out = 1'b1;
                                ld_hit   = flags_reg[in_idx];
                            end
                            CMD_DISARM:
                            begin
                                if (flags_reg[in_idx])
                                begin
                                    flags_next[in_idx] = 1'b0;
                                    remain_next        = len_reg;
                                    state_next         = ST_SCAN;
                                end
                                else
                                begin
                                    load_out = 1'b1;
                                end
                            end
                            CMD_ARM:
                            begin
                                if (flags_reg[in_idx])
                                begin
                                    remain_next = len_reg;
                                    state_next  = ST_SCAN;
                                end
                                else
                                begin
                                    // append at the tail at once
                                    ctl.op              = OP_LOAD;
                                    ctl.ins_data.id     = in_ch.timer_id;
                                    ctl.ins_data.expiry = in_ch.expiry_time;
                                    len_next            = len_reg + 1'b1;
                                    flags_next[in_idx]  = 1'b1;
                                    load_out            = 1'b1;
                                    ld_hit              = 1'b1;
                                end
                            end
                            default:
                            begin
                                load_out = 1'b1;
                            end
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                // hold the scan while a second fired id cannot be passed on
                if (!((cmd_reg == CMD_TICK) && expired && pend_valid_reg && !out_free))
                begin
                    ctl.op      = OP_SHIFT;
                    ins_pos     = len_reg - 1'b1;
                    remain_next = remain_reg - 1'b1;
                    if (drop)
                    begin
                        len_next = len_reg - 1'b1;
                        if (cmd_reg == CMD_TICK)
                        begin
                            flags_next[head_idx] = 1'b0;
                            if (pend_valid_reg)
                            begin
                                load_out = 1'b1;
                                ld_id    = pend_id_reg;
                                ld_hit   = 1'b1;
                                ld_last  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = head.id;
                        end
                    end
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ld_id      = target_reg;
                    ld_hit     = 1'b1;
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_TICK:
                        begin
                            ld_id  = pend_valid_reg ? pend_id_reg : '0;
                            ld_hit = pend_valid_reg;
                        end
                        CMD_ARM:
                        begin
                            // rearmed timer goes to the tail
                            ctl.op                 = OP_LOAD;
                            ctl.ins_data.id        = target_reg;
                            ctl.ins_data.expiry    = exp_reg;
                            len_next               = len_reg + 1'b1;
                            flags_next[target_idx] = 1'b1;
                        end
                        default:
                        begin
                            ld_hit = 1'b1;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_id_next    = out_id_reg;
        out_hit_next   = out_hit_reg;
        out_time_next  = out_time_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_id_next    = ld_id;
            out_hit_next   = ld_hit;
            out_time_next  = now_next;
            out_last_next  = ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            inc_reg        <= TICK_RESET;
            len_reg        <= '0;
            remain_reg     <= '0;
            flags_reg      <= '0;
            cmd_reg        <= CMD_ARM;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            len_reg        <= len_next;
            remain_reg     <= remain_next;
            flags_reg      <= flags_next;
            cmd_reg        <= cmd_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                inc_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        exp_reg      <= exp_next;
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_hit_reg  <= out_hit_next;
        out_time_reg <= out_time_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_id    = out_id_reg;
    assign out_ch.hit          = out_hit_reg;
    assign out_ch.current_time = out_time_reg;
    assign out_ch.last_of_run  = out_last_reg;

endmodule
